// ----- rtl/arps_pkg.sv -----
`timescale 1ns / 1ps

package arps_pkg;

    // Coordinate and color widths.
    localparam int COORD_BITS     = 10;
    localparam int COLOR_BITS     = 24;
    localparam int BYTE_BITS      = 8;
    localparam int NUM_BYTES      = COLOR_BITS / BYTE_BITS;

    // Fixed point: distance and alpha carry eight fractional bits.
    localparam int FRAC_BITS      = 8;
    localparam int ALPHA_BITS     = FRAC_BITS + 1;
    localparam int ALPHA_ONE      = 1 << FRAC_BITS;
    localparam int ALPHA_HALF     = 1 << (FRAC_BITS - 1);

    // Squared distance, radicand and root widths.
    localparam int SQ_BITS        = 2 * COORD_BITS + 1;
    localparam int ROOT_BITS      = (SQ_BITS + 2 * FRAC_BITS + 1) / 2;
    localparam int RADICAND_BITS  = 2 * ROOT_BITS;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_CENTER_X       = 3'd0,
        CFG_CENTER_Y       = 3'd1,
        CFG_RING_RADIUS    = 3'd2,
        CFG_RING_THICKNESS = 3'd3,
        CFG_FORE_COLOR     = 3'd4,
        CFG_BACK_COLOR     = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
    } t_in_item;

    typedef struct packed {
        logic [COORD_BITS-1:0] out_x;
        logic [COORD_BITS-1:0] out_y;
        logic                  write_enable;
        logic [COLOR_BITS-1:0] pixel_color;
    } t_out_item;

endpackage

// ----- rtl/arps_sqrt.sv -----
`timescale 1ns / 1ps

module arps_sqrt (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [arps_pkg::RADICAND_BITS-1:0]  i_radicand,
    input  arps_pkg::t_in_item                  i_tag,
    output logic                                o_valid,
    output logic [arps_pkg::ROOT_BITS-1:0]      o_root,
    output arps_pkg::t_in_item                  o_tag
);
    import arps_pkg::*;

    // Up to two root bits are resolved in each stage; the last stage resolves one.
    localparam int STEPS    = 2;
    localparam int NSTG     = (ROOT_BITS + STEPS - 1) / STEPS;
    localparam int REM_BITS = ROOT_BITS + 3;

    typedef struct packed {
        logic                     valid;
        logic [RADICAND_BITS-1:0] rad;
        logic [REM_BITS-1:0]      rem;
        logic [ROOT_BITS-1:0]     q;
        t_in_item                 tag;
    } t_stage;

    t_stage r_stg [NSTG];
    t_stage n_stg [NSTG];

    always_comb begin
        int j;
        logic [REM_BITS-1:0] rw;
        logic [REM_BITS-1:0] trial;
        for (int k = 0; k < NSTG; k++) begin
            if (k == 0) begin
                n_stg[k].valid = i_valid;
                n_stg[k].rad   = i_radicand;
                n_stg[k].rem   = '0;
                n_stg[k].q     = '0;
                n_stg[k].tag   = i_tag;
            end else begin
                n_stg[k] = r_stg[k-1];
            end
            for (int s = 0; s < STEPS; s++) begin
                j = k * STEPS + s;
                if (j < ROOT_BITS) begin
                    // Bring down the next pair of radicand bits and try 4q+1.
                    rw    = {n_stg[k].rem[REM_BITS-3:0],
                             n_stg[k].rad[2 * (ROOT_BITS - 1 - j) +: 2]};
                    trial = {1'b0, n_stg[k].q, 2'b01};
                    if (rw >= trial) begin
                        n_stg[k].rem = rw - trial;
                        n_stg[k].q   = {n_stg[k].q[ROOT_BITS-2:0], 1'b1};
                    end else begin
                        n_stg[k].rem = rw;
                        n_stg[k].q   = {n_stg[k].q[ROOT_BITS-2:0], 1'b0};
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_stg[k].valid <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < NSTG; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_valid = r_stg[NSTG-1].valid;
    assign o_root  = r_stg[NSTG-1].q;
    assign o_tag   = r_stg[NSTG-1].tag;

endmodule

// ----- rtl/antialiased_ring_pixel_shader.sv -----
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+------------------------------
// pixel in  | input     | i_in_valid / o_in_stall   | i_in_data  (pixel_x, pixel_y)
// result    | output    | o_out_valid / i_out_stall | o_out_data (x, y, we, color)
// config    | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One pixel transaction is accepted per clock while o_in_stall is low; each produces one result
// through 17 pipeline stages, ten of them in the square root, then the output register.
// The sustained rate of one item per cycle, while no stall is held, is set by the pipelined square root,
// which resolves up to two root bits per stage.
// Reset is synchronous and active low; it clears valid bits and loads register defaults.
// A stalled result is caught by a skid register; while it is full, o_in_stall is high.

module antialiased_ring_pixel_shader (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  arps_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output arps_pkg::t_out_item                  o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [arps_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [arps_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import arps_pkg::*;

    localparam int PROD_BITS = ALPHA_BITS + BYTE_BITS;

    // Per-stage payloads. Each carries its own valid bit.
    typedef struct packed {
        logic                  valid;
        t_in_item              tag;
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
    } t_stage_a;

    typedef struct packed {
        logic                    valid;
        t_in_item                tag;
        logic [2*COORD_BITS-1:0] dx2;
        logic [2*COORD_BITS-1:0] dy2;
    } t_stage_b;

    typedef struct packed {
        logic               valid;
        t_in_item           tag;
        logic [SQ_BITS-1:0] sq;
    } t_stage_c;

    typedef struct packed {
        logic                 valid;
        t_in_item             tag;
        logic [ROOT_BITS-1:0] off;
    } t_stage_d;

    typedef struct packed {
        logic                  valid;
        t_in_item              tag;
        logic [ALPHA_BITS-1:0] a8;
    } t_stage_e;

    typedef struct packed {
        logic                                 valid;
        t_in_item                             tag;
        logic                                 we;
        logic [NUM_BYTES-1:0][PROD_BITS-1:0]  pf;
        logic [NUM_BYTES-1:0][PROD_BITS-1:0]  pb;
    } t_stage_f;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_stage_g;

    // Configuration registers. The user must write them only while the block is idle;
    // the block itself does not enforce this, and the stages read them directly.
    logic [COORD_BITS-1:0] r_center_x;
    logic [COORD_BITS-1:0] r_center_y;
    logic [COORD_BITS-1:0] r_radius;
    logic [COORD_BITS-1:0] r_thick;
    logic [COLOR_BITS-1:0] r_fore;
    logic [COLOR_BITS-1:0] r_back;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_radius   <= '0;
            r_thick    <= COORD_BITS'(1);
            r_fore     <= '0;
            r_back     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_CENTER_X:       r_center_x <= i_cfg_data[COORD_BITS-1:0];
                CFG_CENTER_Y:       r_center_y <= i_cfg_data[COORD_BITS-1:0];
                CFG_RING_RADIUS:    r_radius   <= i_cfg_data[COORD_BITS-1:0];
                CFG_RING_THICKNESS: r_thick    <= i_cfg_data[COORD_BITS-1:0];
                CFG_FORE_COLOR:     r_fore     <= i_cfg_data[COLOR_BITS-1:0];
                CFG_BACK_COLOR:     r_back     <= i_cfg_data[COLOR_BITS-1:0];
                default: begin
                    // Indexes past the register list are ignored.
                end
            endcase
        end
    end

    // The whole pipeline advances together unless the skid register is holding
    // a result that the output register could not take.
    logic     r_skid_valid;
    t_out_item r_skid;
    logic     r_out_valid;
    t_out_item r_out;
    logic     w_en;
    logic     w_out_ready;

    assign w_en        = !r_skid_valid;
    assign o_in_stall  = r_skid_valid;
    assign w_out_ready = !r_out_valid || !i_out_stall;

    t_stage_a r_a, n_a;
    t_stage_b r_b, n_b;
    t_stage_c r_c, n_c;
    t_stage_d r_d, n_d;
    t_stage_e r_e, n_e;
    t_stage_f r_f, n_f;
    t_stage_g r_g, n_g;

    logic                     w_sq_valid;
    logic [ROOT_BITS-1:0]     w_root;
    t_in_item                 w_sq_tag;
    logic [RADICAND_BITS-1:0] w_radicand;

    // Stage A: absolute offsets from the center.
    always_comb begin
        n_a.valid = i_in_valid;
        n_a.tag   = i_in_data;
        n_a.dx    = (i_in_data.pixel_x >= r_center_x) ? i_in_data.pixel_x - r_center_x
                                                      : r_center_x - i_in_data.pixel_x;
        n_a.dy    = (i_in_data.pixel_y >= r_center_y) ? i_in_data.pixel_y - r_center_y
                                                      : r_center_y - i_in_data.pixel_y;
    end

    // Stage B: squares of the offsets.
    always_comb begin
        n_b.valid = r_a.valid;
        n_b.tag   = r_a.tag;
        n_b.dx2   = (2*COORD_BITS)'(r_a.dx) * (2*COORD_BITS)'(r_a.dx);
        n_b.dy2   = (2*COORD_BITS)'(r_a.dy) * (2*COORD_BITS)'(r_a.dy);
    end

    // Stage C: squared distance.
    always_comb begin
        n_c.valid = r_b.valid;
        n_c.tag   = r_b.tag;
        n_c.sq    = SQ_BITS'(r_b.dx2) + SQ_BITS'(r_b.dy2);
    end

    // The square root of the squared distance scaled by 2^16 gives the
    // distance with eight fractional bits.
    assign w_radicand = RADICAND_BITS'(r_c.sq) << (2 * FRAC_BITS);

    arps_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_c.valid),
        .i_radicand (w_radicand),
        .i_tag      (r_c.tag),
        .o_valid    (w_sq_valid),
        .o_root     (w_root),
        .o_tag      (w_sq_tag)
    );

    // Stage D: distance from the ring centerline.
    always_comb begin
        logic [ROOT_BITS-1:0] radius_fix;
        radius_fix = ROOT_BITS'({r_radius, FRAC_BITS'(0)});
        n_d.valid  = w_sq_valid;
        n_d.tag    = w_sq_tag;
        n_d.off    = (w_root >= radius_fix) ? w_root - radius_fix : radius_fix - w_root;
    end

    // Stage E: coverage is half a pixel plus half the thickness minus the
    // offset, saturated to the range from zero to one.
    always_comb begin
        logic [ROOT_BITS-1:0]      lim;
        logic signed [ROOT_BITS:0] cov;
        lim = ROOT_BITS'({r_thick, (FRAC_BITS - 1)'(0)}) + ROOT_BITS'(ALPHA_HALF);
        cov = $signed({1'b0, lim}) - $signed({1'b0, r_d.off});
        n_e.valid = r_d.valid;
        n_e.tag   = r_d.tag;
        if (cov[ROOT_BITS]) begin
            n_e.a8 = '0;
        end else if (cov > $signed((ROOT_BITS + 1)'(ALPHA_ONE))) begin
            n_e.a8 = ALPHA_BITS'(ALPHA_ONE);
        end else begin
            n_e.a8 = cov[ALPHA_BITS-1:0];
        end
    end

    // Stage F: weighted foreground and background bytes.
    always_comb begin
        logic [ALPHA_BITS-1:0] na;
        na        = ALPHA_BITS'(ALPHA_ONE) - r_e.a8;
        n_f.valid = r_e.valid;
        n_f.tag   = r_e.tag;
        n_f.we    = (r_e.a8 != '0);
        for (int i = 0; i < NUM_BYTES; i++) begin
            n_f.pf[i] = PROD_BITS'(r_e.a8) * PROD_BITS'(r_fore[i*BYTE_BITS +: BYTE_BITS]);
            n_f.pb[i] = PROD_BITS'(na) * PROD_BITS'(r_back[i*BYTE_BITS +: BYTE_BITS]);
        end
    end

    // Stage G: blend sums, truncated; uncovered pixels report black.
    always_comb begin
        logic [PROD_BITS-1:0] sum;
        n_g.valid             = r_f.valid;
        n_g.item.out_x        = r_f.tag.pixel_x;
        n_g.item.out_y        = r_f.tag.pixel_y;
        n_g.item.write_enable = r_f.we;
        n_g.item.pixel_color  = '0;
        for (int i = 0; i < NUM_BYTES; i++) begin
            sum = r_f.pf[i] + r_f.pb[i];
            if (r_f.we) begin
                n_g.item.pixel_color[i*BYTE_BITS +: BYTE_BITS] = sum[FRAC_BITS +: BYTE_BITS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_b.valid <= 1'b0;
            r_c.valid <= 1'b0;
            r_d.valid <= 1'b0;
            r_e.valid <= 1'b0;
            r_f.valid <= 1'b0;
            r_g.valid <= 1'b0;
        end else if (w_en) begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
            r_d <= n_d;
            r_e <= n_e;
            r_f <= n_f;
            r_g <= n_g;
        end
    end

    // Output register with a skid slot. When the output can move, it takes the
    // skid entry first, otherwise the last pipeline stage. When it cannot move,
    // a result leaving the pipeline parks in the skid slot, which freezes the
    // pipeline on the following cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid  <= r_skid_valid || r_g.valid;
            r_out        <= r_skid_valid ? r_skid : r_g.item;
            r_skid_valid <= 1'b0;
        end else if (w_en && r_g.valid) begin
            r_skid_valid <= 1'b1;
            r_skid       <= r_g.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The skid slot is only ever filled behind a waiting output.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without a pending output");

    // A result leaving the pipeline into a stalled output must land in the skid slot.
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_g.valid && r_out_valid && i_out_stall && !r_skid_valid) |=> r_skid_valid)
        else $error("result dropped at stalled output");

    // Coverage never exceeds one.
    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e.valid |-> (r_e.a8 <= ALPHA_BITS'(ALPHA_ONE)))
        else $error("coverage out of range");

    // Uncovered pixels report a zero color.
    a_zero_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.write_enable) |-> (o_out_data.pixel_color == '0))
        else $error("nonzero color on unwritten pixel");

endmodule
